@@ sv/kqt_pkg.sv @@
// Shared types, sizes and codes for the keyed quantity table.
package kqt_pkg;

    // Table geometry and field widths.
    localparam int TABLE_DEPTH = 16;
    localparam int QTY_BITS    = 16;
    localparam int ID_BITS     = 8;
    localparam int IN_QTY_BITS = 16;
    localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
    localparam int SUM_BITS    = ((QTY_BITS > IN_QTY_BITS) ? QTY_BITS : IN_QTY_BITS) + 1;
    localparam int ENTRY_BITS  = ID_BITS + QTY_BITS;

    // Largest storable quantity, at the width of the adder.
    localparam logic [SUM_BITS-1:0] QTY_MAX = SUM_BITS'({QTY_BITS{1'b1}});

    // Operation codes carried by the mode field.
    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_LOOKUP = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_READ   = 2'd3
    } mode_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_BAD_INDEX = 2'd2
    } status_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ADD_WB,
        ST_APPEND,
        ST_READ,
        ST_READ_DONE,
        ST_RM_READ,
        ST_RM_MOVE,
        ST_RM_CLEAR,
        ST_DONE
    } state_t;

    // One stored table entry.
    typedef struct packed {
        logic [ID_BITS-1:0]  id;
        logic [QTY_BITS-1:0] qty;
    } entry_t;

    // One finished result, handed from the sequencer to the output stage.
    typedef struct packed {
        status_t             status;
        logic                hit;
        logic [ID_BITS-1:0]  id;
        logic [QTY_BITS-1:0] qty;
        logic [IDX_BITS-1:0] idx;
        logic [CNT_BITS-1:0] count;
    } result_t;

endpackage

@@ sv/kqt_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module kqt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; read data holds while re is low.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/kqt_alu.sv @@
// Shared key compare and saturating quantity adder.
module kqt_alu (
    input  logic [kqt_pkg::ID_BITS-1:0]     probe_id,
    input  kqt_pkg::entry_t                 entry,
    input  logic [kqt_pkg::QTY_BITS-1:0]    acc_qty,
    input  logic [kqt_pkg::IN_QTY_BITS-1:0] add_qty,
    output logic                            match,
    output logic [kqt_pkg::QTY_BITS-1:0]    sum_qty
);

    logic [kqt_pkg::SUM_BITS-1:0] sum;

    // An entry matches only when its id agrees and it still holds a quantity.
    assign match = (entry.id == probe_id) && (entry.qty != '0);

    // Add and clamp at the largest storable quantity.
    assign sum = kqt_pkg::SUM_BITS'(acc_qty) + kqt_pkg::SUM_BITS'(add_qty);

    always_comb
    begin
        if (sum > kqt_pkg::QTY_MAX)
        begin
            sum_qty = kqt_pkg::QTY_MAX[kqt_pkg::QTY_BITS-1:0];
        end
        else
        begin
            sum_qty = sum[kqt_pkg::QTY_BITS-1:0];
        end
    end

endmodule

@@ sv/kqt_core.sv @@
// Sequencer, table storage and shared unit of the keyed quantity table.
module kqt_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      mode,
    input  logic [kqt_pkg::ID_BITS-1:0]     item_id,
    input  logic [kqt_pkg::IN_QTY_BITS-1:0] quantity,
    input  logic [3:0]                      entry_index,
    output logic                            res_valid,
    output kqt_pkg::result_t                res,
    input  logic                            res_taken
);

    // Control registers.
    kqt_pkg::state_t               state_reg, state_next;
    logic [kqt_pkg::CNT_BITS-1:0]  count_reg, count_next;
    logic [kqt_pkg::CNT_BITS-1:0]  scan_reg, scan_next;
    logic                          chk_valid_reg, chk_valid_next;

    // Payload registers.
    kqt_pkg::mode_t                  op_mode_reg, op_mode_next;
    logic [kqt_pkg::ID_BITS-1:0]     op_id_reg, op_id_next;
    logic [kqt_pkg::IN_QTY_BITS-1:0] op_qty_reg, op_qty_next;
    logic [kqt_pkg::IDX_BITS-1:0]    op_idx_reg, op_idx_next;
    logic [kqt_pkg::IDX_BITS-1:0]    chk_idx_reg, chk_idx_next;
    kqt_pkg::entry_t                 hold_reg, hold_next;
    logic [kqt_pkg::IDX_BITS-1:0]    hold_idx_reg, hold_idx_next;
    kqt_pkg::status_t                rs_status_reg, rs_status_next;
    logic                            rs_hit_reg, rs_hit_next;
    kqt_pkg::entry_t                 rs_entry_reg, rs_entry_next;
    logic [kqt_pkg::IDX_BITS-1:0]    rs_idx_reg, rs_idx_next;

    // Memory and shared unit connections.
    logic                             ram_we, ram_re;
    logic [kqt_pkg::IDX_BITS-1:0]     ram_waddr, ram_raddr;
    kqt_pkg::entry_t                  ram_wdata, ram_rdata;
    logic [kqt_pkg::QTY_BITS-1:0]     alu_acc;
    logic                             alu_match;
    logic [kqt_pkg::QTY_BITS-1:0]     alu_sum;

    // Decode helpers.
    kqt_pkg::mode_t                   in_mode;
    logic                             in_accept;
    logic                             idx_bad;
    logic                             idx_last;
    logic                             scan_issue;
    logic                             scan_found;
    logic [kqt_pkg::CNT_BITS-1:0]     last_slot;

    assign in_mode    = kqt_pkg::mode_t'(mode);
    assign in_ready   = (state_reg == kqt_pkg::ST_IDLE);
    assign in_accept  = in_valid && in_ready;
    assign idx_bad    = (32'(entry_index) >= 32'(count_reg));
    assign idx_last   = (32'(entry_index) == (32'(count_reg) - 32'd1));
    assign last_slot  = count_reg - kqt_pkg::CNT_BITS'(1);
    assign scan_issue = (scan_reg < count_reg);
    assign scan_found = chk_valid_reg && alu_match;

    kqt_ram #(
        .WIDTH (kqt_pkg::ENTRY_BITS),
        .DEPTH (kqt_pkg::TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    kqt_alu u_alu (
        .probe_id (op_id_reg),
        .entry    (ram_rdata),
        .acc_qty  (alu_acc),
        .add_qty  (op_qty_reg),
        .match    (alu_match),
        .sum_qty  (alu_sum)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kqt_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_mode inside {kqt_pkg::MODE_ADD, kqt_pkg::MODE_LOOKUP})
                    begin
                        state_next = kqt_pkg::ST_SCAN;
                    end
                    else if (idx_bad)
                    begin
                        state_next = kqt_pkg::ST_DONE;
                    end
                    else if (in_mode == kqt_pkg::MODE_READ)
                    begin
                        state_next = kqt_pkg::ST_READ;
                    end
                    else if (idx_last)
                    begin
                        state_next = kqt_pkg::ST_RM_CLEAR;
                    end
                    else
                    begin
                        state_next = kqt_pkg::ST_RM_READ;
                    end
                end
            end
            kqt_pkg::ST_SCAN:
            begin
                if (scan_found)
                begin
                    state_next = (op_mode_reg == kqt_pkg::MODE_ADD) ?
                                 kqt_pkg::ST_ADD_WB : kqt_pkg::ST_DONE;
                end
                else if (!scan_issue)
                begin
                    if ((op_mode_reg == kqt_pkg::MODE_ADD) &&
                        (32'(count_reg) < kqt_pkg::TABLE_DEPTH))
                    begin
                        state_next = kqt_pkg::ST_APPEND;
                    end
                    else
                    begin
                        state_next = kqt_pkg::ST_DONE;
                    end
                end
            end
            kqt_pkg::ST_ADD_WB:    state_next = kqt_pkg::ST_DONE;
            kqt_pkg::ST_APPEND:    state_next = kqt_pkg::ST_DONE;
            kqt_pkg::ST_READ:      state_next = kqt_pkg::ST_READ_DONE;
            kqt_pkg::ST_READ_DONE: state_next = kqt_pkg::ST_DONE;
            kqt_pkg::ST_RM_READ:   state_next = kqt_pkg::ST_RM_MOVE;
            kqt_pkg::ST_RM_MOVE:   state_next = kqt_pkg::ST_RM_CLEAR;
            kqt_pkg::ST_RM_CLEAR:  state_next = kqt_pkg::ST_DONE;
            kqt_pkg::ST_DONE:
            begin
                if (res_taken)
                begin
                    state_next = kqt_pkg::ST_IDLE;
                end
            end
            default:               state_next = kqt_pkg::ST_IDLE;
        endcase
    end

    // Memory controls, shared unit operands and register updates.
    always_comb
    begin
        ram_we         = 1'b0;
        ram_waddr      = op_idx_reg;
        ram_wdata      = hold_reg;
        ram_re         = 1'b0;
        ram_raddr      = scan_reg[kqt_pkg::IDX_BITS-1:0];
        alu_acc        = '0;
        count_next     = count_reg;
        scan_next      = scan_reg;
        chk_valid_next = chk_valid_reg;
        op_mode_next   = op_mode_reg;
        op_id_next     = op_id_reg;
        op_qty_next    = op_qty_reg;
        op_idx_next    = op_idx_reg;
        chk_idx_next   = chk_idx_reg;
        hold_next      = hold_reg;
        hold_idx_next  = hold_idx_reg;
        rs_status_next = rs_status_reg;
        rs_hit_next    = rs_hit_reg;
        rs_entry_next  = rs_entry_reg;
        rs_idx_next    = rs_idx_reg;
        case (state_reg)
            kqt_pkg::ST_IDLE:
            begin
                // Capture the transaction and preset an empty result.
                if (in_accept)
                begin
                    op_mode_next   = in_mode;
                    op_id_next     = item_id;
                    op_qty_next    = quantity;
                    op_idx_next    = kqt_pkg::IDX_BITS'(entry_index);
                    scan_next      = '0;
                    chk_valid_next = 1'b0;
                    hold_next      = '0;
                    rs_status_next = kqt_pkg::STATUS_OK;
                    rs_hit_next    = 1'b0;
                    rs_entry_next  = '0;
                    rs_idx_next    = '0;
                    if (!(in_mode inside {kqt_pkg::MODE_ADD, kqt_pkg::MODE_LOOKUP}) &&
                        idx_bad)
                    begin
                        rs_status_next = kqt_pkg::STATUS_BAD_INDEX;
                    end
                end
            end
            kqt_pkg::ST_SCAN:
            begin
                // Issue one slot a cycle and check the slot issued in the previous cycle.
                ram_re         = scan_issue;
                scan_next      = scan_reg + kqt_pkg::CNT_BITS'(1);
                chk_valid_next = scan_issue;
                chk_idx_next   = scan_reg[kqt_pkg::IDX_BITS-1:0];
                if (scan_found)
                begin
                    ram_re        = 1'b0;
                    hold_next     = ram_rdata;
                    hold_idx_next = chk_idx_reg;
                    rs_hit_next   = 1'b1;
                    rs_entry_next = ram_rdata;
                    rs_idx_next   = chk_idx_reg;
                end
                else if (!scan_issue && (op_mode_reg == kqt_pkg::MODE_ADD) &&
                         (32'(count_reg) >= kqt_pkg::TABLE_DEPTH))
                begin
                    rs_status_next = kqt_pkg::STATUS_FULL;
                end
            end
            kqt_pkg::ST_ADD_WB:
            begin
                // Accumulate into the matched slot.
                alu_acc         = hold_reg.qty;
                ram_we          = 1'b1;
                ram_waddr       = hold_idx_reg;
                ram_wdata.id    = hold_reg.id;
                ram_wdata.qty   = alu_sum;
                rs_entry_next.qty = alu_sum;
            end
            kqt_pkg::ST_APPEND:
            begin
                // New entry at the end of the live slots.
                alu_acc         = '0;
                ram_we          = 1'b1;
                ram_waddr       = count_reg[kqt_pkg::IDX_BITS-1:0];
                ram_wdata.id    = op_id_reg;
                ram_wdata.qty   = alu_sum;
                rs_entry_next.id  = op_id_reg;
                rs_entry_next.qty = alu_sum;
                rs_idx_next     = count_reg[kqt_pkg::IDX_BITS-1:0];
                count_next      = count_reg + kqt_pkg::CNT_BITS'(1);
            end
            kqt_pkg::ST_READ:
            begin
                ram_re    = 1'b1;
                ram_raddr = op_idx_reg;
            end
            kqt_pkg::ST_READ_DONE:
            begin
                rs_entry_next = ram_rdata;
                rs_idx_next   = op_idx_reg;
            end
            kqt_pkg::ST_RM_READ:
            begin
                ram_re    = 1'b1;
                ram_raddr = last_slot[kqt_pkg::IDX_BITS-1:0];
            end
            kqt_pkg::ST_RM_MOVE:
            begin
                // Move the last entry into the freed slot.
                ram_we    = 1'b1;
                ram_waddr = op_idx_reg;
                ram_wdata = ram_rdata;
                hold_next = ram_rdata;
            end
            kqt_pkg::ST_RM_CLEAR:
            begin
                // Clear the old last slot and shrink the table.
                ram_we        = 1'b1;
                ram_waddr     = last_slot[kqt_pkg::IDX_BITS-1:0];
                ram_wdata     = '0;
                count_next    = last_slot;
                rs_entry_next = hold_reg;
                rs_idx_next   = op_idx_reg;
            end
            kqt_pkg::ST_DONE:
            begin
                ram_we = 1'b0;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kqt_pkg::ST_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            chk_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_mode_reg   <= op_mode_next;
        op_id_reg     <= op_id_next;
        op_qty_reg    <= op_qty_next;
        op_idx_reg    <= op_idx_next;
        chk_idx_reg   <= chk_idx_next;
        hold_reg      <= hold_next;
        hold_idx_reg  <= hold_idx_next;
        rs_status_reg <= rs_status_next;
        rs_hit_reg    <= rs_hit_next;
        rs_entry_reg  <= rs_entry_next;
        rs_idx_reg    <= rs_idx_next;
    end

    // Result toward the output stage.
    assign res_valid    = (state_reg == kqt_pkg::ST_DONE);
    assign res.status   = rs_status_reg;
    assign res.hit      = rs_hit_reg;
    assign res.id       = rs_entry_reg.id;
    assign res.qty      = rs_entry_reg.qty;
    assign res.idx      = rs_idx_reg;
    assign res.count    = count_reg;

    // The live count never passes the table depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= kqt_pkg::TABLE_DEPTH)
        else $error("live count exceeds table depth");

    // The live count moves only on append or remove.
    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != kqt_pkg::ST_APPEND) && (state_reg != kqt_pkg::ST_RM_CLEAR)
        |=> $stable(count_reg))
        else $error("live count changed outside append or remove");

    // An append grows the table by exactly one entry.
    a_append_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kqt_pkg::ST_APPEND)
        |=> (count_reg == $past(count_reg) + kqt_pkg::CNT_BITS'(1)))
        else $error("append did not grow the table by one");

    // A write during accumulate lands inside the live slots.
    a_wb_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kqt_pkg::ST_ADD_WB) |-> (32'(hold_idx_reg) < 32'(count_reg)))
        else $error("accumulate write outside live slots");

endmodule

@@ sv/keyed_quantity_table_top.sv @@
// Top level of the keyed quantity table: input capture, sequencer and output register.
//
// Usage:
//   The input channel (in_valid / in_stall) carries one operation per
//   transaction: mode selects add, lookup by id, remove by index or read by
//   index; item_id, quantity and entry_index are its operands. The output
//   channel (out_valid / out_stall) returns exactly one result transaction
//   per operation, in order.
//   Add and lookup scan the live slots one per cycle through the table RAM
//   read port. in_stall is high while an operation is in progress; one
//   item is in work at a time. The finished result sits in an output
//   register, so the next operation is accepted while it waits. If the
//   receiver stalls, the result holds and a later result waits in the
//   sequencer until the register frees. Reset empties the table (live
//   count 0) and clears both channels; the RAM contents are not cleared,
//   since only live slots are ever read.
module keyed_quantity_table_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [7:0]  item_id,
    input  logic [15:0] quantity,
    input  logic [3:0]  entry_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        hit,
    output logic [7:0]  out_item_id,
    output logic [15:0] out_quantity,
    output logic [3:0]  out_index,
    output logic [4:0]  entry_count
);

    logic             core_ready;
    logic             res_valid;
    logic             res_taken;
    kqt_pkg::result_t res;
    logic             out_valid_reg, out_valid_next;
    kqt_pkg::result_t out_reg;

    kqt_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (core_ready),
        .mode        (mode),
        .item_id     (item_id),
        .quantity    (quantity),
        .entry_index (entry_index),
        .res_valid   (res_valid),
        .res         (res),
        .res_taken   (res_taken)
    );

    assign in_stall = !core_ready;

    // Load the output register whenever it is empty or being drained.
    assign res_taken = res_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        if (res_taken)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_taken)
        begin
            out_reg <= res;
        end
    end

    // Drive the result ports at their field widths.
    assign out_valid    = out_valid_reg;
    assign status       = out_reg.status;
    assign hit          = out_reg.hit;
    assign out_item_id  = out_reg.id;
    assign out_quantity = 16'(out_reg.qty);
    assign out_index    = 4'(out_reg.idx);
    assign entry_count  = 5'(out_reg.count);

endmodule
